@@ rtl/svpwm_pkg.sv @@
// shared types, widths and constants for the svpwm compare block
package svpwm_pkg;

  // timer width, range 8 to 32
  localparam int CNT_W  = 16;
  localparam int FRAC   = 24;
  localparam int COEF_W = 24;
  localparam int VOLT_W = 20;
  localparam int HP_W   = 16;
  localparam int CMP_W  = 16;
  localparam int CFG_W  = 24;
  localparam int CFG_IDX_W = 2;

  // signed coefficient (with a zero sign bit) times a signed voltage
  localparam int PROD_W = COEF_W + 1 + VOLT_W;
  localparam int XY_W   = 48;
  localparam int PQ_W   = CNT_W + FRAC;
  // non-negative sector times, wide enough for x/y differences and for P in Q.24
  localparam int T_W    = (PQ_W > XY_W - 1) ? PQ_W : XY_W - 1;
  localparam int R_W    = T_W + 2;

  localparam logic [COEF_W-1:0] RST_COEF_X_ALPHA = 24'd4352000;
  localparam logic [COEF_W-1:0] RST_COEF_X_BETA  = 24'd2512628;
  localparam logic [COEF_W-1:0] RST_COEF_Y_BETA  = 24'd5025253;
  localparam logic [HP_W-1:0]   RST_HALF_PERIOD  = 16'd4250;

  localparam logic [CFG_IDX_W-1:0] CFG_COEF_X_ALPHA = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_X_BETA  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_Y_BETA  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD  = 2'd3;

  // which phase gets the smallest compare value (zero under overmodulation)
  typedef enum logic [1:0] {
    SEC_ZERO_C = 2'd0,
    SEC_ZERO_A = 2'd1,
    SEC_ZERO_B = 2'd2
  } sector_t;

  // item data that rides alongside the divider
  typedef struct packed {
    sector_t        sector;
    logic           lim;
    logic           big_first;
    logic           both_big;
    logic           zero_small;
    logic [T_W-1:0] u;
    logic [T_W-1:0] v;
    logic [T_W-1:0] t0;
  } side_t;

  typedef struct packed {
    logic [T_W-1:0]   num;
    logic [T_W-1:0]   den;
    logic [R_W-1:0]   rem;
    logic [CNT_W-1:0] quo;
    side_t            side;
  } div_t;

endpackage

@@ rtl/svpwm_in_if.sv @@
// input channel: one voltage vector per transfer
interface svpwm_in_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [svpwm_pkg::VOLT_W-1:0]     alpha_volts;
  logic signed [svpwm_pkg::VOLT_W-1:0]     beta_volts;

  modport source (output valid, output alpha_volts, output beta_volts, input ready);
  modport sink   (input valid, input alpha_volts, input beta_volts, output ready);
endinterface

@@ rtl/svpwm_out_if.sv @@
// result channel: three timer compare values per transfer
interface svpwm_out_if;
  logic                             valid;
  logic                             ready;
  logic [svpwm_pkg::CMP_W-1:0]      compare_a;
  logic [svpwm_pkg::CMP_W-1:0]      compare_b;
  logic [svpwm_pkg::CMP_W-1:0]      compare_c;

  modport source (output valid, output compare_a, output compare_b, output compare_c,
                  input ready);
  modport sink   (input valid, input compare_a, input compare_b, input compare_c,
                  output ready);
endinterface

@@ rtl/svpwm_div.sv @@
// pipelined restoring divider giving floor(p * num / den), one bit of p per stage
module svpwm_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic [svpwm_pkg::CNT_W-1:0]  p,
  input  logic                         in_valid,
  input  svpwm_pkg::div_t              in_data,
  output logic                         out_valid,
  output svpwm_pkg::div_t              out_data
);

  svpwm_pkg::div_t             chain [svpwm_pkg::CNT_W+1];
  logic [svpwm_pkg::CNT_W:0]   vchain;

  assign chain[0]  = in_data;
  assign vchain[0] = in_valid;

  for (genvar k = 0; k < svpwm_pkg::CNT_W; k++) begin : g_step
    svpwm_pkg::div_t                 src;
    svpwm_pkg::div_t                 stage_nxt;
    svpwm_pkg::div_t                 stage_r;
    logic                            valid_r;
    logic [svpwm_pkg::R_W-1:0]       den_w;
    logic [svpwm_pkg::R_W-1:0]       r1;
    logic [svpwm_pkg::R_W-1:0]       r2;
    logic [svpwm_pkg::R_W-1:0]       r3;
    logic                            c1;
    logic                            c2;

    assign src = chain[k];

    always_comb begin
      den_w = svpwm_pkg::R_W'(src.den);
      // remainder stays below den, so doubling plus num stays below 3 * den
      r1 = {src.rem[svpwm_pkg::R_W-2:0], 1'b0}
         + (p[svpwm_pkg::CNT_W-1-k] ? svpwm_pkg::R_W'(src.num) : '0);
      c1 = (r1 >= den_w);
      r2 = c1 ? (r1 - den_w) : r1;
      c2 = (r2 >= den_w);
      r3 = c2 ? (r2 - den_w) : r2;
      stage_nxt      = src;
      stage_nxt.rem  = r3;
      stage_nxt.quo  = {src.quo[svpwm_pkg::CNT_W-2:0], 1'b0}
                     + svpwm_pkg::CNT_W'(c1) + svpwm_pkg::CNT_W'(c2);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r <= 1'b0;
      end else if (en) begin
        valid_r <= vchain[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stage_r <= stage_nxt;
      end
    end

    assign chain[k+1]  = stage_r;
    assign vchain[k+1] = valid_r;
  end

  assign out_valid = vchain[svpwm_pkg::CNT_W];
  assign out_data  = chain[svpwm_pkg::CNT_W];

endmodule

@@ rtl/svpwm_compare_with_overmodulation.sv @@
// space-vector pwm compare generator with proportional overmodulation
//
// in_ch takes one (alpha, beta) voltage vector per transfer, signed Q8.12 volts.
// out_ch gives one transfer per vector with the phase A, B and C timer compare
// values, in the order the vectors came in.
// cfg_we/cfg_index/cfg_wdata write the three axis coefficients and the half
// period; writes take effect at once. The user must make writes only while no
// vector is in flight; the block itself does not enforce this.
// from input transfer to result a vector passes the registers for the multipliers,
// the axis sums, the sector pick and the overmodulation compares, then the divider
// pipeline, and the output register.
// throughput is one vector per cycle while out_ch is not stalled; every stage carries its own valid bit.
// the whole pipeline advances together whenever the output register is empty
// or being taken, so a stall at out_ch holds every stage and drops in_ch.ready
// in the same cycle; nothing is lost or repeated.
// reset clears all valid bits and loads the default coefficients and half
// period (4250 counts).
module svpwm_compare_with_overmodulation (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [svpwm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [svpwm_pkg::CFG_W-1:0]       cfg_wdata,
  svpwm_in_if.sink                          in_ch,
  svpwm_out_if.source                       out_ch
);

  localparam int CNT_W = svpwm_pkg::CNT_W;
  localparam int T_W   = svpwm_pkg::T_W;
  localparam int R_W   = svpwm_pkg::R_W;
  localparam int XY_W  = svpwm_pkg::XY_W;
  localparam int PROD_W = svpwm_pkg::PROD_W;
  localparam int FRAC  = svpwm_pkg::FRAC;
  localparam int CMP_W = svpwm_pkg::CMP_W;

  // configuration registers
  logic [svpwm_pkg::COEF_W-1:0] coef_xa_r;
  logic [svpwm_pkg::COEF_W-1:0] coef_xb_r;
  logic [svpwm_pkg::COEF_W-1:0] coef_yb_r;
  logic [svpwm_pkg::HP_W-1:0]   half_period_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_xa_r     <= svpwm_pkg::RST_COEF_X_ALPHA;
      coef_xb_r     <= svpwm_pkg::RST_COEF_X_BETA;
      coef_yb_r     <= svpwm_pkg::RST_COEF_Y_BETA;
      half_period_r <= svpwm_pkg::RST_HALF_PERIOD;
    end else if (cfg_we) begin
      case (cfg_index)
        svpwm_pkg::CFG_COEF_X_ALPHA: coef_xa_r     <= cfg_wdata[svpwm_pkg::COEF_W-1:0];
        svpwm_pkg::CFG_COEF_X_BETA:  coef_xb_r     <= cfg_wdata[svpwm_pkg::COEF_W-1:0];
        svpwm_pkg::CFG_COEF_Y_BETA:  coef_yb_r     <= cfg_wdata[svpwm_pkg::COEF_W-1:0];
        svpwm_pkg::CFG_HALF_PERIOD:  half_period_r <= cfg_wdata[svpwm_pkg::HP_W-1:0];
        default: ;
      endcase
    end
  end

  // half period at timer width, and in Q.24
  logic [CNT_W-1:0] p;
  logic [T_W-1:0]   pq;
  assign p  = CNT_W'(half_period_r);
  assign pq = T_W'(p) << FRAC;

  // global advance: output register empty or being taken
  logic en;
  logic out_valid_r;
  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  // stage 1: projections
  logic                      s1_valid_r;
  logic signed [PROD_W-1:0]  pxa_r;
  logic signed [PROD_W-1:0]  pxb_r;
  logic signed [PROD_W-1:0]  pyb_r;

  // stage 2: axis values
  logic                      s2_valid_r;
  logic signed [XY_W-1:0]    x_r;
  logic signed [XY_W-1:0]    y_r;

  // stage 3: sector and its pair of times
  logic                      s3_valid_r;
  svpwm_pkg::sector_t        sec_r;
  svpwm_pkg::sector_t        sec_nxt;
  logic [T_W-1:0]            u_r;
  logic [T_W-1:0]            v_r;
  logic [T_W-1:0]            u_nxt;
  logic [T_W-1:0]            v_nxt;

  // stage 4: overmodulation classification, divider operands
  logic                      s4_valid_r;
  svpwm_pkg::div_t           s4_r;
  svpwm_pkg::div_t           s4_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_ch.valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= s3_valid_r;
    end
  end

  // sector pick from the signs of x and y, and from x versus y when either is negative (a tie picks SEC_ZERO_A)
  always_comb begin
    logic signed [XY_W-1:0] du;
    logic signed [XY_W-1:0] dv;
    if (!x_r[XY_W-1] && !y_r[XY_W-1]) begin
      sec_nxt = svpwm_pkg::SEC_ZERO_C;
      du      = x_r;
      dv      = y_r;
    end else if (x_r <= y_r) begin
      sec_nxt = svpwm_pkg::SEC_ZERO_A;
      du      = y_r - x_r;
      dv      = -x_r;
    end else begin
      sec_nxt = svpwm_pkg::SEC_ZERO_B;
      du      = x_r - y_r;
      dv      = -y_r;
    end
    // both are non-negative here
    u_nxt = T_W'(du[XY_W-2:0]);
    v_nxt = T_W'(dv[XY_W-2:0]);
  end

  // overmodulation compares against P
  always_comb begin
    logic           u_le;
    logic           v_le;
    logic           uv_ge;
    logic [T_W-1:0] big;
    logic [T_W-1:0] small_t;
    u_le    = (u_r <= pq);
    v_le    = (v_r <= pq);
    uv_ge   = (u_r >= v_r);
    big     = uv_ge ? u_r : v_r;
    small_t = uv_ge ? v_r : u_r;
    s4_nxt                  = '0;
    s4_nxt.num              = small_t;
    s4_nxt.den              = big;
    s4_nxt.side.sector      = sec_r;
    s4_nxt.side.lim         = !(u_le && v_le);
    s4_nxt.side.big_first   = uv_ge;
    s4_nxt.side.both_big    = (u_r >= pq) && (v_r >= pq);
    s4_nxt.side.zero_small  = ((big - small_t) >= pq);
    s4_nxt.side.u           = u_r;
    s4_nxt.side.v           = v_r;
    // zero time, only meaningful when no limit applies
    s4_nxt.side.t0          = pq - big;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pxa_r <= $signed({1'b0, coef_xa_r}) * in_ch.alpha_volts;
      pxb_r <= $signed({1'b0, coef_xb_r}) * in_ch.beta_volts;
      pyb_r <= $signed({1'b0, coef_yb_r}) * in_ch.beta_volts;
      x_r   <= -(XY_W'(pxa_r) + XY_W'(pxb_r));
      y_r   <= -XY_W'(pyb_r);
      sec_r <= sec_nxt;
      u_r   <= u_nxt;
      v_r   <= v_nxt;
      s4_r  <= s4_nxt;
    end
  end

  // proportional scaling floor(P * small / large)
  logic             dv_valid;
  svpwm_pkg::div_t  dv_data;

  svpwm_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .p         (p),
    .in_valid  (s4_valid_r),
    .in_data   (s4_r),
    .out_valid (dv_valid),
    .out_data  (dv_data)
  );

  // final times: first/second of the pair and the zeroed phase
  logic [CMP_W-1:0] first_t;
  logic [CMP_W-1:0] second_t;
  logic [CMP_W-1:0] zero_t;
  logic [CMP_W-1:0] cmp_a_nxt;
  logic [CMP_W-1:0] cmp_b_nxt;
  logic [CMP_W-1:0] cmp_c_nxt;

  always_comb begin
    svpwm_pkg::side_t sd;
    logic [R_W-1:0]   sum_u;
    logic [R_W-1:0]   sum_v;
    logic [CMP_W-1:0] big_c;
    logic [CMP_W-1:0] small_c;
    sd    = dv_data.side;
    sum_u = (R_W'(sd.u) << 1) + R_W'(sd.t0);
    sum_v = (R_W'(sd.v) << 1) + R_W'(sd.t0);
    big_c = CMP_W'(p);
    if (sd.both_big) begin
      small_c = CMP_W'(p);
    end else if (sd.zero_small) begin
      small_c = '0;
    end else begin
      small_c = CMP_W'(dv_data.quo);
    end
    if (!sd.lim) begin
      // half the zero time added, truncated from Q.25
      first_t  = CMP_W'(sum_u >> (FRAC + 1));
      second_t = CMP_W'(sum_v >> (FRAC + 1));
      zero_t   = CMP_W'(sd.t0 >> (FRAC + 1));
    end else begin
      first_t  = sd.big_first ? big_c : small_c;
      second_t = sd.big_first ? small_c : big_c;
      zero_t   = '0;
    end
    case (sd.sector)
      svpwm_pkg::SEC_ZERO_A: begin
        cmp_a_nxt = zero_t;
        cmp_b_nxt = first_t;
        cmp_c_nxt = second_t;
      end
      svpwm_pkg::SEC_ZERO_B: begin
        cmp_a_nxt = first_t;
        cmp_b_nxt = zero_t;
        cmp_c_nxt = second_t;
      end
      default: begin
        cmp_a_nxt = first_t;
        cmp_b_nxt = second_t;
        cmp_c_nxt = zero_t;
      end
    endcase
  end

  // output register
  logic [CMP_W-1:0] cmp_a_r;
  logic [CMP_W-1:0] cmp_b_r;
  logic [CMP_W-1:0] cmp_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmp_a_r <= cmp_a_nxt;
      cmp_b_r <= cmp_b_nxt;
      cmp_c_r <= cmp_c_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.compare_a = cmp_a_r;
  assign out_ch.compare_b = cmp_b_r;
  assign out_ch.compare_c = cmp_c_r;

endmodule
